// ===== src/iss_pkg.sv =====
// Shared types for the insertion sorter: data width, cell control and
// the one-hot sequencer state. No dependencies.
package iss_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic insert;  // place the arriving value into the chain
    logic shift;   // move every entry one cell toward the output
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

// ===== src/iss_cell.sv =====
// One cell of the sorting chain: holds one entry and its valid bit.
// Depends on iss_pkg for the data type and the control struct.
module iss_cell (
  input  logic               clk,
  input  logic               rst,
  input  iss_pkg::cell_ctrl_t ctrl,
  input  iss_pkg::data_t     in_value,
  input  iss_pkg::data_t     left_value,
  input  logic               left_valid,
  input  logic               left_gt,
  input  iss_pkg::data_t     right_value,
  input  logic               right_valid,
  output iss_pkg::data_t     value,
  output logic               valid,
  output logic               gt
);

  // An empty cell counts as greater than anything; strict compare keeps
  // equal values in arrival order.
  assign gt = !valid || (value > in_value);

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        valid <= left_valid;
      end else if (gt) begin
        valid <= 1'b1;
      end
    end
  end

  // Move the entry: from the right on emit, from the left or the new
  // value on insert, otherwise hold
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        value <= left_value;
      end else if (gt) begin
        value <= in_value;
      end
    end
  end

endmodule

// ===== src/insertion_sort_ascending.sv =====
// Stable ascending insertion sorter built as a chain of sorting cells.
// Depends on iss_pkg and iss_cell.
//
// Usage:
//   Values enter on the s_ stream, one per transfer; s_tlast marks the
//   last value of a set. Each value is placed in its sorted position as
//   it is accepted, so a set loads back to back at one value per cycle.
//   On the transfer carrying s_tlast the chain switches to emit: the sorted
//   set leaves on the m_ stream from cell 0, smallest first, one entry per
//   cycle while m_tready is high, with m_tlast on the largest entry.
//   The first result is valid the cycle after the last input transfer.
//   s_tready is low while a set is being emitted. A stall on m_tready
//   holds the chain unchanged. Values arriving with the chain full are
//   dropped, but their s_tlast still starts the emit. Reset empties the
//   chain and returns to loading.
module insertion_sort_ascending #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast    // final_res
);

  iss_pkg::state_t       state;
  iss_pkg::state_t       state_next;
  iss_pkg::cell_ctrl_t   ctrl;
  iss_pkg::data_t        in_value;
  iss_pkg::data_t        cell_value [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] cell_valid;
  logic [MAX_ELEMENTS-1:0] cell_gt;
  logic                  in_xfer;
  logic                  out_xfer;

  assign in_value = iss_pkg::data_t'(s_tdata);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // Handshake: load while in load state, present cell 0 while emitting
  assign s_tready = (state == iss_pkg::ST_LOAD);
  assign m_tvalid = (state == iss_pkg::ST_EMIT);
  assign m_tdata  = 32'(cell_value[0]);
  assign m_tlast  = !cell_valid[1];

  // Drop the value when the last cell is occupied
  assign ctrl.insert = in_xfer && !cell_valid[MAX_ELEMENTS-1];
  assign ctrl.shift  = out_xfer;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      iss_pkg::ST_LOAD: begin
        if (in_xfer && s_tlast) state_next = iss_pkg::ST_EMIT;
      end
      iss_pkg::ST_EMIT: begin
        if (out_xfer && m_tlast) state_next = iss_pkg::ST_LOAD;
      end
      default: state_next = iss_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iss_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Chain of cells, cell 0 holds the smallest entry
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    iss_pkg::data_t left_value;
    logic           left_valid;
    logic           left_gt;
    iss_pkg::data_t right_value;
    logic           right_valid;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_valid = 1'b0;
      assign left_gt    = 1'b0;
    end else begin : g_mid_left
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_end
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    iss_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .in_value    (in_value),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .left_gt     (left_gt),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

`ifndef SYNTHESIS
  // Emit always has at least one entry to show
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cell_valid[0])
    else $error("emit with empty chain");

  // A last input starts the emit on the next cycle
  a_last_starts_emit: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("last input did not start emit");

  // Final output leaves the chain empty
  a_empty_after_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (cell_valid == '0))
    else $error("chain not empty after final output");

  // Occupied cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells not contiguous");
`endif

endmodule

// ===== verif/tb_insertion_sort_ascending.sv =====
// Self-checking testbench for insertion_sort_ascending: drives sets of signed values
// on the s_ stream and checks each sorted transfer on the m_ stream against a local model.
// Depends on iss_pkg and the insertion_sort_ascending RTL.
module tb_insertion_sort_ascending;

  typedef iss_pkg::data_t data_t;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned MAX_GAP    = 17;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned ITEM_GOAL  = 420;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned CYCLE_CAP  = 500000;

  localparam data_t VAL_MIN = 32'sh8000_0000;
  localparam data_t VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    data_t value;
    logic  tail;
  } sorted_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] sorted_value
  logic        m_tlast;        // final_res

  // Local copy of the sorted store
  data_t        sort_store [DEPTH];
  int unsigned  fill_count = 0;
  sorted_item_t pending_sorted [$];

  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;
  bit          tx_fast      = 1'b0;
  bit          rx_fast      = 1'b0;
  bit          rx_long_hold = 1'b0;

  insertion_sort_ascending #(.MAX_ELEMENTS(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Place one accepted value; on the last marker, queue the whole sorted set
  task automatic sort_accepted(input data_t v, input logic last_flag);
    int unsigned pos;
    sorted_item_t item;
    if (fill_count < DEPTH) begin
      pos = fill_count;
      while (pos > 0 && sort_store[pos-1] > v) begin
        sort_store[pos] = sort_store[pos-1];
        pos--;
      end
      sort_store[pos] = v;
      fill_count++;
    end
    if (last_flag) begin
      for (int unsigned k = 0; k < fill_count; k++) begin
        item.value = sort_store[k];
        item.tail  = (k + 1 == fill_count);
        pending_sorted.push_back(item);
      end
      fill_count = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Offer one value after a random gap and hold it until the transfer
  task automatic send_value(input data_t v, input logic last_flag);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sort_accepted(v, last_flag);
    items_sent++;
  endtask

  // Stop offering and wait until every queued result has been transferred
  task automatic wait_sorted_drain();
    s_tvalid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(0, 4))
      0: return data_t'($urandom_range(0, 7)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_random_set(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_value(pick_value(), i + 1 == count);
  endtask

  // Two sets of one element, at the top and at the bottom of the range
  task automatic test_single_value();
    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MIN, 1'b1);
    wait_sorted_drain();
  endtask

  // Range extremes, duplicates and a descending run
  task automatic test_extremes();
    data_t mix [8];
    mix = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN, VAL_MAX, 32'sh5555_AAAA};
    foreach (mix[i]) send_value(mix[i], i == 7);
    for (int i = 5; i > 0; i--) send_value(data_t'(i * 1000 - 2500), i == 1);
    send_value(7, 1'b0);
    send_value(7, 1'b0);
    send_value(-7, 1'b1);
    wait_sorted_drain();
  endtask

  // Fill the store exactly, then overflow it with the last marker on a dropped value
  task automatic test_store_full();
    send_random_set(DEPTH);
    wait_sorted_drain();
    tx_fast = 1'b1;
    send_random_set(DEPTH + 3);
    tx_fast = 1'b0;
    wait_sorted_drain();
  endtask

  // Hold the receiver off while further sets are offered behind the first
  task automatic test_output_stall();
    rx_long_hold = 1'b1;
    send_random_set(8);
    send_random_set(6);
    send_random_set(3);
    wait_sorted_drain();
  endtask

  // Mostly small sets with random content, some at full rate
  task automatic test_random_sets();
    int unsigned count;
    while (items_sent < ITEM_GOAL) begin
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      tx_fast = ($urandom_range(0, 4) == 0);
      rx_fast = ($urandom_range(0, 4) == 0);
      send_random_set(count);
      if ($urandom_range(0, 3) == 0) wait_sorted_drain();
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    wait_sorted_drain();
  endtask

  // Receiver: draw a stall per result, or a long hold when requested
  initial begin : rx_driver
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_long_hold) begin
        stall = LONG_HOLD;
        rx_long_hold = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid && !rx_long_hold) @(posedge clk);
    end
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    sorted_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", $signed(m_tdata)));
      end else begin
        want = pending_sorted.pop_front();
        if (data_t'(m_tdata) !== want.value)
          report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    $signed(m_tdata), want.value));
        if (m_tlast !== want.tail)
          report_mismatch($sformatf("final_res %0b, expected %0b", m_tlast, want.tail));
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("insertion_sort_ascending test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_value();
    test_extremes();
    test_output_stall();
    test_store_full();
    test_random_sets();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_sorted.size()));
    if (mismatches == 0)
      $display("insertion_sort_ascending test passed");
    else
      $display("insertion_sort_ascending test failed");
    $finish;
  end

endmodule

// ===== insertion_sort_ascending.f =====
src/iss_pkg.sv
src/iss_cell.sv
src/insertion_sort_ascending.sv
verif/tb_insertion_sort_ascending.sv
